@@ src/fgs_pkg.sv @@
// Types, constants and rule tables shared by the fuzzy gain scheduler.
`timescale 1ns / 1ps
package fgs_pkg;

	// Register map.
	localparam int ADDR_W = 3;
	localparam logic REG_ERROR_SCALE = 1'b0;
	localparam logic REG_RATE_SCALE  = 1'b1;

	localparam int SCALE_W = 15;
	localparam logic [SCALE_W-1:0] ERROR_SCALE_RST = 15'd1229;
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 15'd6144;

	// Level arithmetic: Q7.8 times Q4.12 gives Q.20.
	localparam int LVL_W = 31;
	localparam logic signed [LVL_W-1:0] LVL_SAT = 31'sd6291456;
	localparam int U_W = 24;
	localparam logic [U_W-1:0] LVL_SAT_U = 24'd6291456;

	// Memberships are Q.21, from zero to one inclusive.
	localparam int MEM_W = 22;
	localparam logic [MEM_W-1:0] MEM_ONE = 22'd2097152;

	// Weight products and rule-weighted terms.
	localparam int W_W = 43;
	localparam int PROD_W = 47;
	localparam logic signed [PROD_W-1:0] ROUND_OFS = 47'sd805306368;

	// Final divide by six.
	localparam int HI_W = 19;
	localparam logic signed [HI_W-1:0] POS_OFS = 19'sd98304;
	localparam int T_W = 18;
	localparam int X_W = 17;
	localparam logic [X_W-1:0] RECIP3 = 17'd87382;
	localparam int RECIP_SHIFT = 18;
	localparam logic signed [15:0] OUT_ONE = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] error;
		logic signed [15:0] error_rate;
	} in_data_t;

	typedef struct packed {
		logic signed [15:0] p_adjust;
		logic signed [15:0] d_adjust;
	} out_data_t;

	typedef struct packed {
		logic [2:0]       seg;
		logic [MEM_W-1:0] upper;
		logic [MEM_W-1:0] lower;
	} fuzz_t;

	typedef logic signed [3:0] rule_t;

	localparam rule_t P_RULES [0:6][0:6] = '{
		'{ 4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd4,  4'sd0},
		'{ 4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd4,  4'sd2,  4'sd0},
		'{ 4'sd6,  4'sd4,  4'sd2,  4'sd2,  4'sd0, -4'sd2, -4'sd4},
		'{ 4'sd4,  4'sd4,  4'sd2,  4'sd6,  4'sd6, -4'sd2, -4'sd2},
		'{-4'sd6, -4'sd4, -4'sd2,  4'sd6,  4'sd6,  4'sd4,  4'sd6},
		'{ 4'sd0,  4'sd2,  4'sd4,  4'sd6,  4'sd4,  4'sd6,  4'sd6},
		'{ 4'sd0,  4'sd4,  4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd6}
	};

	localparam rule_t D_RULES [0:6][0:6] = '{
		'{ 4'sd6,  4'sd4,  4'sd2, -4'sd2,  4'sd0, -4'sd2, -4'sd2},
		'{ 4'sd6,  4'sd4,  4'sd2,  4'sd0, -4'sd2, -4'sd4, -4'sd6},
		'{ 4'sd6,  4'sd4,  4'sd2,  4'sd0,  4'sd0, -4'sd2,  4'sd2},
		'{ 4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd3,  4'sd2},
		'{ 4'sd2, -4'sd2,  4'sd0,  4'sd0,  4'sd2,  4'sd4,  4'sd6},
		'{-4'sd6, -4'sd4, -4'sd2,  4'sd0,  4'sd2,  4'sd4,  4'sd6},
		'{-4'sd2, -4'sd2,  4'sd0, -4'sd2,  4'sd2,  4'sd4,  4'sd6}
	};

endpackage

@@ src/fuzzy_gain_scheduler_unit.sv @@
// Top level of the fuzzy gain scheduler: six-stage inference pipeline and its registers.
`timescale 1ns / 1ps
// An accepted request passes through stage registers 1 to 6; stage 6 is the output register.
// Throughput: one request per cycle; the pipeline is fully stallable and each stage
// moves on whenever the stage after it is empty or moving, so bubbles are squeezed out.
// Reset: arst_n clears every valid bit at once and loads both scale registers with their
// reset values; payload registers are not reset.
module fuzzy_gain_scheduler_unit
	import fgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Request channel.
	input  logic              in_valid,
	output logic              in_stall,
	input  in_data_t          in_data,
	// Result channel.
	output logic              out_valid,
	input  logic              out_stall,
	output out_data_t         out_data,
	// APB-style configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// ------------------------------------------------------------------
	// Configuration registers. Register i sits at byte address 4*i, so
	// address bit 2 selects between the two scales.
	// ------------------------------------------------------------------
	logic [SCALE_W-1:0] error_scale_q;
	logic [SCALE_W-1:0] rate_scale_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_scale_q <= ERROR_SCALE_RST;
			rate_scale_q  <= RATE_SCALE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ERROR_SCALE: error_scale_q <= pwdata[SCALE_W-1:0];
				REG_RATE_SCALE:  rate_scale_q  <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ERROR_SCALE: prdata = {{(32-SCALE_W){1'b0}}, error_scale_q};
			REG_RATE_SCALE:  prdata = {{(32-SCALE_W){1'b0}}, rate_scale_q};
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage loads when it is empty or when the
	// stage after it is loading, so a stalled result only holds back the
	// stages that are actually full behind it.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6      = !v_s6 || !out_stall;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: scale each sample to a level. Q7.8 times Q4.12 gives an
	// exact Q.20 level that fits in 31 signed bits.
	// ------------------------------------------------------------------
	logic signed [LVL_W-1:0] e_lvl_s1, r_lvl_s1;
	logic signed [31:0]      e_prod, r_prod;

	assign e_prod = in_data.error * $signed({1'b0, error_scale_q});
	assign r_prod = in_data.error_rate * $signed({1'b0, rate_scale_q});

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			e_lvl_s1 <= e_prod[LVL_W-1:0];
			r_lvl_s1 <= r_prod[LVL_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: saturate the level to [-6,6], find the segment between two
	// neighbouring sets and the triangular memberships of both sets. A
	// level of exactly +6 stays in the last segment with full upper
	// membership.
	// ------------------------------------------------------------------
	function automatic fuzz_t fuzzify(input logic signed [LVL_W-1:0] lvl);
		logic signed [LVL_W-1:0] sat;
		logic [U_W-1:0]          u;
		fuzz_t                   f;
		if (lvl > LVL_SAT) begin
			sat = LVL_SAT;
		end else if (lvl < -LVL_SAT) begin
			sat = -LVL_SAT;
		end else begin
			sat = lvl;
		end
		u = sat[U_W-1:0] + LVL_SAT_U;
		if (u[U_W-1:U_W-3] == 3'd6) begin
			f.seg   = 3'd5;
			f.upper = MEM_ONE;
		end else begin
			f.seg   = u[U_W-1:U_W-3];
			f.upper = {1'b0, u[U_W-4:0]};
		end
		f.lower = MEM_ONE - f.upper;
		return f;
	endfunction

	fuzz_t e_fz_s2, r_fz_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			e_fz_s2 <= fuzzify(e_lvl_s1);
			r_fz_s2 <= fuzzify(r_lvl_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: the four membership products (exact, Q.42, at most one)
	// and the eight rule lookups. Index pairs are lower/upper error set
	// by lower/upper rate set.
	// ------------------------------------------------------------------
	logic [2:0]      es_lo, es_hi, cs_lo, cs_hi;
	logic [2*MEM_W-1:0] m_ll, m_lu, m_ul, m_uu;
	logic [W_W-1:0]  w_ll_s3, w_lu_s3, w_ul_s3, w_uu_s3;
	rule_t           p_ll_s3, p_lu_s3, p_ul_s3, p_uu_s3;
	rule_t           d_ll_s3, d_lu_s3, d_ul_s3, d_uu_s3;

	assign es_lo = e_fz_s2.seg;
	assign es_hi = 3'(e_fz_s2.seg + 3'd1);
	assign cs_lo = r_fz_s2.seg;
	assign cs_hi = 3'(r_fz_s2.seg + 3'd1);

	assign m_ll = e_fz_s2.lower * r_fz_s2.lower;
	assign m_lu = e_fz_s2.lower * r_fz_s2.upper;
	assign m_ul = e_fz_s2.upper * r_fz_s2.lower;
	assign m_uu = e_fz_s2.upper * r_fz_s2.upper;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			w_ll_s3 <= m_ll[W_W-1:0];
			w_lu_s3 <= m_lu[W_W-1:0];
			w_ul_s3 <= m_ul[W_W-1:0];
			w_uu_s3 <= m_uu[W_W-1:0];
			p_ll_s3 <= P_RULES[es_lo][cs_lo];
			p_lu_s3 <= P_RULES[es_lo][cs_hi];
			p_ul_s3 <= P_RULES[es_hi][cs_lo];
			p_uu_s3 <= P_RULES[es_hi][cs_hi];
			d_ll_s3 <= D_RULES[es_lo][cs_lo];
			d_lu_s3 <= D_RULES[es_lo][cs_hi];
			d_ul_s3 <= D_RULES[es_hi][cs_lo];
			d_uu_s3 <= D_RULES[es_hi][cs_hi];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: weight each rule by its membership product. The rules are
	// small signed constants, so each term is a narrow multiply.
	// ------------------------------------------------------------------
	function automatic logic signed [PROD_W-1:0] weigh(input rule_t r,
	                                                    input logic [W_W-1:0] w);
		logic signed [PROD_W-1:0] ws;
		ws = $signed({{(PROD_W-W_W){1'b0}}, w});
		return r * ws;
	endfunction

	logic signed [PROD_W-1:0] p_t_s4 [4];
	logic signed [PROD_W-1:0] d_t_s4 [4];

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			p_t_s4[0] <= weigh(p_ll_s3, w_ll_s3);
			p_t_s4[1] <= weigh(p_lu_s3, w_lu_s3);
			p_t_s4[2] <= weigh(p_ul_s3, w_ul_s3);
			p_t_s4[3] <= weigh(p_uu_s3, w_uu_s3);
			d_t_s4[0] <= weigh(d_ll_s3, w_ll_s3);
			d_t_s4[1] <= weigh(d_lu_s3, w_lu_s3);
			d_t_s4[2] <= weigh(d_ul_s3, w_ul_s3);
			d_t_s4[3] <= weigh(d_uu_s3, w_uu_s3);
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sum the terms and begin the rounded divide by 6*2^28. The
	// half-divisor is added first, the 2^28 part is a shift, and an
	// offset of six times one makes the dividend nonnegative so that the
	// remaining divide by six floors correctly.
	// ------------------------------------------------------------------
	function automatic logic [T_W-1:0] pre_div(input logic signed [PROD_W-1:0] t0,
	                                           input logic signed [PROD_W-1:0] t1,
	                                           input logic signed [PROD_W-1:0] t2,
	                                           input logic signed [PROD_W-1:0] t3);
		logic signed [PROD_W-1:0] s;
		logic signed [HI_W-1:0]   hi;
		logic signed [HI_W-1:0]   pos;
		s   = t0 + t1 + t2 + t3 + ROUND_OFS;
		hi  = s[PROD_W-1:PROD_W-HI_W];
		pos = hi + POS_OFS;
		return pos[T_W-1:0];
	endfunction

	logic [T_W-1:0] p_n_s5, d_n_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			p_n_s5 <= pre_div(p_t_s4[0], p_t_s4[1], p_t_s4[2], p_t_s4[3]);
			d_n_s5 <= pre_div(d_t_s4[0], d_t_s4[1], d_t_s4[2], d_t_s4[3]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: divide by six as a halving followed by a reciprocal
	// multiply for the divide by three (exact for dividends below 2^17),
	// then remove the offset to give the Q1.14 result.
	// ------------------------------------------------------------------
	function automatic logic signed [15:0] post_div(input logic [T_W-1:0] n);
		logic [X_W-1:0]   x;
		logic [2*X_W-1:0] m;
		logic [15:0]      q;
		x = n[T_W-1:1];
		m = x * RECIP3;
		q = m[RECIP_SHIFT+15:RECIP_SHIFT];
		return $signed(q) - OUT_ONE;
	endfunction

	out_data_t res_s6;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			res_s6.p_adjust <= post_div(p_n_s5);
			res_s6.d_adjust <= post_div(d_n_s5);
		end
	end

	assign out_data = res_s6;

endmodule

@@ tb/sv/gain_adjust_checker.sv @@
// Checker that predicts the fuzzy gain scheduler's P and D adjustments and compares each result.
`timescale 1ns / 1ps
module gain_adjust_checker
	import fgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  in_data_t          in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  out_data_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending
);

	localparam longint LEVEL_SAT  = 64'sd6291456;    // 6.0 in Q.20
	localparam longint MEMBER_ONE = 64'sd2097152;    // 1.0 in Q.21
	localparam longint SIX_DIV    = 64'sd1610612736; // 6 * 2^28: Q.42 sum to Q1.14, over six
	localparam longint ADJ_ONE    = 64'sd16384;
	localparam int PRINT_CAP = 40;

	// Rule tables, rows by error set and columns by rate set, NB to PB.
	localparam int P_TABLE [0:6][0:6] = '{
		'{ 6,  6,  6,  6,  6,  4,  0},
		'{ 6,  6,  6,  6,  4,  2,  0},
		'{ 6,  4,  2,  2,  0, -2, -4},
		'{ 4,  4,  2,  6,  6, -2, -2},
		'{-6, -4, -2,  6,  6,  4,  6},
		'{ 0,  2,  4,  6,  4,  6,  6},
		'{ 0,  4,  6,  6,  6,  6,  6}
	};

	localparam int D_TABLE [0:6][0:6] = '{
		'{ 6,  4,  2, -2,  0, -2, -2},
		'{ 6,  4,  2,  0, -2, -4, -6},
		'{ 6,  4,  2,  0,  0, -2,  2},
		'{ 2, -2, -2, -2, -2, -3,  2},
		'{ 2, -2,  0,  0,  2,  4,  6},
		'{-6, -4, -2,  0,  2,  4,  6},
		'{-2, -2,  0, -2,  2,  4,  6}
	};

	logic [SCALE_W-1:0] error_factor = ERROR_SCALE_RST;
	logic [SCALE_W-1:0] rate_factor = RATE_SCALE_RST;
	out_data_t adjust_queue [$];
	out_data_t oldest;
	int mismatch_total = 0;

	assign fail_count = mismatch_total;

	task automatic report_mismatch(input string text);
		mismatch_total++;
		if (mismatch_total <= PRINT_CAP) begin
			$display("%0t ns: %s", $time, text);
		end
	endtask

	function automatic int rule_value(input bit d_path, input int row, input int col);
		return d_path ? D_TABLE[row][col] : P_TABLE[row][col];
	endfunction

	// Saturates the level and returns the lower set of its segment and the upper set's membership.
	function automatic void locate_level(input logic signed [15:0] sample,
			input logic [SCALE_W-1:0] factor, output int set, output longint upper);
		longint level;
		level = longint'(sample) * longint'(factor);
		if (level > LEVEL_SAT) begin
			level = LEVEL_SAT;
		end else if (level < -LEVEL_SAT) begin
			level = -LEVEL_SAT;
		end
		level = level + LEVEL_SAT;
		set = int'(level / MEMBER_ONE);
		if (set > 5) begin
			set = 5;
		end
		upper = level - longint'(set) * MEMBER_ONE;
	endfunction

	function automatic logic signed [15:0] weigh_rules(input bit d_path, input int e_set,
			input longint e_up, input int r_set, input longint r_up);
		longint e_low;
		longint r_low;
		longint acc;
		longint q;
		e_low = MEMBER_ONE - e_up;
		r_low = MEMBER_ONE - r_up;
		acc = longint'(rule_value(d_path, e_set, r_set)) * (e_low * r_low)
			+ longint'(rule_value(d_path, e_set, r_set + 1)) * (e_low * r_up)
			+ longint'(rule_value(d_path, e_set + 1, r_set)) * (e_up * r_low)
			+ longint'(rule_value(d_path, e_set + 1, r_set + 1)) * (e_up * r_up);
		// Offset to a non-negative numerator so that truncation rounds ties upwards.
		q = (acc + ADJ_ONE * SIX_DIV + SIX_DIV / 2) / SIX_DIV - ADJ_ONE;
		return q[15:0];
	endfunction

	function automatic out_data_t predict_adjust(input in_data_t req);
		int e_set;
		int r_set;
		longint e_up;
		longint r_up;
		out_data_t res;
		locate_level(req.error, error_factor, e_set, e_up);
		locate_level(req.error_rate, rate_factor, r_set, r_up);
		res.p_adjust = weigh_rules(1'b0, e_set, e_up, r_set, r_up);
		res.d_adjust = weigh_rules(1'b1, e_set, e_up, r_set, r_up);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_factor = ERROR_SCALE_RST;
			rate_factor = RATE_SCALE_RST;
			adjust_queue.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (adjust_queue.size() == 0) begin
					report_mismatch($sformatf("result with none expected: p_adjust %0d d_adjust %0d",
						out_data.p_adjust, out_data.d_adjust));
				end else begin
					oldest = adjust_queue.pop_front();
					if (out_data.p_adjust !== oldest.p_adjust) begin
						report_mismatch($sformatf("p_adjust is %0d, expected %0d",
							out_data.p_adjust, oldest.p_adjust));
					end
					if (out_data.d_adjust !== oldest.d_adjust) begin
						report_mismatch($sformatf("d_adjust is %0d, expected %0d",
							out_data.d_adjust, oldest.d_adjust));
					end
				end
			end
			if (in_valid && !in_stall) begin
				adjust_queue.push_back(predict_adjust(in_data));
			end
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				if (paddr[ADDR_W-1:2] == REG_ERROR_SCALE) begin
					error_factor = pwdata[SCALE_W-1:0];
				end else if (paddr[ADDR_W-1:2] == REG_RATE_SCALE) begin
					rate_factor = pwdata[SCALE_W-1:0];
				end
			end
			pending <= adjust_queue.size();
		end
	end

endmodule

@@ tb/sv/fuzzy_gain_scheduler_unit_test.sv @@
// Top of the fuzzy gain scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fuzzy_gain_scheduler_unit_test;
	import fgs_pkg::*;

	// Watchdog limit, set well above what the slowest correct run needs.
	localparam int CYCLE_LIMIT = 200000;
	localparam int BATCH_SIZE = 250;
	localparam int HOLD_CYCLES = 48;
	localparam int SETTLE_CYCLES = 12;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_data_t          in_data;
	logic              out_valid;
	logic              out_stall;
	out_data_t         out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int fail_count;
	int pending;
	int cycle_count;

	// Idling odds in percent, and the number of long hold-offs asked of the receiver so far.
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;

	// The scales as last written, used only to aim the random requests at useful levels.
	logic [SCALE_W-1:0] cur_error_scale;
	logic [SCALE_W-1:0] cur_rate_scale;

	fuzzy_gain_scheduler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	gain_adjust_checker adjust_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one request from a falling edge, after a random number of idle cycles, and holds
	// it steady until a rising edge sees it taken with the stall low.
	task automatic send_request(input in_data_t req);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_pair(input int err, input int rate);
		in_data_t req;
		req.error = err[15:0];
		req.error_rate = rate[15:0];
		send_request(req);
	endtask

	// Withdraws the request channel and waits until every expected result has been taken.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// An APB-style register write. The upper data bits carry noise, which the block must mask off.
	task automatic write_scale(input logic reg_index, input logic [SCALE_W-1:0] value);
		logic [31:0] word;
		word = $urandom();
		word[SCALE_W-1:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_index, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_index == REG_ERROR_SCALE) begin
			cur_error_scale = value;
		end else begin
			cur_rate_scale = value;
		end
	endtask

	// Picks a sample for the given scale. Most land inside the unsaturated span of levels, where
	// the memberships actually vary; the rest are raw 16-bit noise, points on or next to a set
	// centre, and the extremes of the field and of the span, zero and minus one.
	function automatic int pick_sample(input logic [SCALE_W-1:0] factor);
		int span;
		int centre;
		int x;
		span = (factor == 0) ? 32767 : 6291456 / int'(factor);
		if (span > 32767) begin
			span = 32767;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				x = int'($urandom_range(0, 2 * span)) - span;
			end
			6, 7: begin
				x = int'($urandom_range(0, 65535)) - 32768;
			end
			8: begin
				centre = int'($urandom_range(0, 6)) * 2 - 6;
				x = (factor == 0) ? 0 : (centre * 1048576) / int'(factor);
				x = x + int'($urandom_range(0, 2)) - 1;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: x = -32768;
					1: x = 32767;
					2: x = span;
					3: x = -span;
					4: x = 0;
					default: x = -1;
				endcase
			end
		endcase
		if (x > 32767) begin
			x = 32767;
		end else if (x < -32768) begin
			x = -32768;
		end
		return x;
	endfunction

	task automatic run_random(input int count, input bit with_hold);
		for (int i = 0; i < count; i++) begin
			// Partway through, the receiver is asked to hold off so that the pipeline backs up.
			if (with_hold && i == count / 3) begin
				hold_requests++;
			end
			send_pair(pick_sample(cur_error_scale), pick_sample(cur_rate_scale));
		end
	endtask

	// Receiver: decides the result stall once per cycle. A long hold-off is counted out here,
	// while the sender carries on offering requests.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: a run that has not finished by the limit is a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 16;
		recv_idle_pct = 71;
		hold_requests = 0;
		cur_error_scale = ERROR_SCALE_RST;
		cur_rate_scale = RATE_SCALE_RST;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset scales (error about 6/20, rate 6/4).
		// Both levels zero, every corner of the field ranges, which saturate, then one extreme with the other zero.
		send_pair(0, 0);
		send_pair(32767, 32767);
		send_pair(-32768, -32768);
		send_pair(32767, -32768);
		send_pair(-32768, 32767);
		send_pair(-32768, 0);
		send_pair(0, 32767);
		// A rate of 4.0 gives a level of exactly six, which must use the top segment with
		// full PB membership; minus 4.0 gives exactly minus six.
		send_pair(0, 1024);
		send_pair(0, -1024);
		// Rate levels of exactly three and just under two.
		send_pair(0, 512);
		send_pair(0, 341);
		// An error of 20.0 lands just past six and saturates; one step less sits just inside.
		send_pair(5120, 0);
		send_pair(5119, 0);
		send_pair(-5120, 0);
		send_pair(-5119, 0);
		// Mixed interior points spread across different rule cells.
		send_pair(1707, 683);
		send_pair(2560, -512);
		send_pair(3413, -2048);
		send_pair(-2560, 700);
		send_pair(-1, 1);
		send_pair(1, -1);
		drain();

		// Six settings with a batch of random requests each. Every register write happens only
		// once the block has drained. The idling pattern moves from an eager sender with a slow
		// receiver, to the reverse, to no idling at all.
		for (int batch = 0; batch < 6; batch++) begin
			case (batch)
				0: begin
					write_scale(REG_ERROR_SCALE, 15'd1);
					write_scale(REG_RATE_SCALE, 15'd1);
				end
				1: begin
					write_scale(REG_ERROR_SCALE, 15'd32767);
					write_scale(REG_RATE_SCALE, 15'd32767);
				end
				2: begin
					// A zero scale pins that level at zero.
					write_scale(REG_ERROR_SCALE, 15'd0);
					write_scale(REG_RATE_SCALE, 15'd4096);
				end
				3: begin
					write_scale(REG_ERROR_SCALE, 15'd4096);
					write_scale(REG_RATE_SCALE, 15'd0);
				end
				4: begin
					write_scale(REG_ERROR_SCALE, SCALE_W'($urandom_range(1, 32767)));
					write_scale(REG_RATE_SCALE, SCALE_W'($urandom_range(1, 32767)));
				end
				default: begin
					write_scale(REG_ERROR_SCALE, ERROR_SCALE_RST);
					write_scale(REG_RATE_SCALE, RATE_SCALE_RST);
				end
			endcase
			if (batch == 2) begin
				send_idle_pct = 71;
				recv_idle_pct = 16;
			end else if (batch == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_random(BATCH_SIZE, batch == 1 || batch == 4);
			drain();
		end

		// Give any stray result time to appear before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
